[rtl/core/btl_pkg.sv]
package btl_pkg;

  // Field widths of the item and result words
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned X100_W  = 23;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_A_W = 2;

  // Default table depths
  localparam int unsigned LEVEL_DEPTH_DEF = 256;
  localparam int unsigned STEP_DEPTH_DEF  = 256;

  // Luminance scale and its operand width
  localparam int unsigned LUM_SCALE = 100;
  localparam int unsigned SCALE_W   = 7;

  localparam logic [X100_W-1:0] X100_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_LEVEL_BRT = 2'd0,
    OP_LEVEL_LUM = 2'd1,
    OP_STEP_BRT  = 2'd2,
    OP_QUERY     = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_WRITE = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_LEVEL_COUNT = 2'd0,
    CFG_STEP_COUNT  = 2'd1,
    CFG_UI_COUNT    = 2'd2,
    CFG_HBM_COUNT   = 2'd3
  } cfg_idx_e;

endpackage

[rtl/core/btl_search.sv]
module btl_search import btl_pkg::*; #(
  parameter int unsigned IW = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [VAL_W-1:0] key_i,
  input  logic [IW-1:0]    n_i,
  output logic [IW-1:0]    rd_addr_o,
  input  logic [VAL_W-1:0] rd_data_i,
  output logic             done_o,
  output logic [IW-1:0]    index_o
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_RD_FIRST  = 7'b0000010,
    S_CMP_FIRST = 7'b0000100,
    S_RD_LAST   = 7'b0001000,
    S_CMP_LAST  = 7'b0010000,
    S_PROBE     = 7'b0100000,
    S_CMP_MID   = 7'b1000000
  } srch_state_e;

  srch_state_e      state_q, state_d;
  logic             done_q, done_d;
  logic [VAL_W-1:0] key_q, key_d;
  logic [IW-1:0]    n_q, n_d;
  logic [IW-1:0]    lo_q, lo_d;
  logic [IW-1:0]    hi1_q, hi1_d;   // one past the upper bound
  logic [IW-1:0]    mid_q, mid_d;
  logic [IW-1:0]    index_q, index_d;
  logic [IW-1:0]    last;
  logic [IW-1:0]    lo_n, hi1_n, mid_n;

  assign last = n_q - IW'(1);

  always_comb begin
    case (state_q)
      S_RD_LAST: rd_addr_o = last;
      S_PROBE:   rd_addr_o = mid_q;
      default:   rd_addr_o = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    key_d   = key_q;
    n_d     = n_q;
    lo_d    = lo_q;
    hi1_d   = hi1_q;
    mid_d   = mid_q;
    index_d = index_q;

    // narrow the window around the probed entry
    lo_n  = lo_q;
    hi1_n = hi1_q;
    if (rd_data_i < key_q) begin
      lo_n = mid_q + IW'(1);
    end else begin
      hi1_n = mid_q;
    end
    mid_n = lo_n + ((hi1_n - lo_n - IW'(1)) >> 1);

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          key_d   = key_i;
          n_d     = n_i;
          state_d = S_RD_FIRST;
        end
      end
      S_RD_FIRST: state_d = S_CMP_FIRST;
      S_CMP_FIRST: begin
        if (key_q <= rd_data_i) begin
          index_d = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_RD_LAST;
        end
      end
      S_RD_LAST: state_d = S_CMP_LAST;
      S_CMP_LAST: begin
        if (key_q >= rd_data_i) begin
          index_d = last;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          lo_d    = '0;
          hi1_d   = n_q;
          mid_d   = last >> 1;
          state_d = S_PROBE;
        end
      end
      S_PROBE: state_d = S_CMP_MID;
      S_CMP_MID: begin
        if (rd_data_i == key_q) begin
          index_d = mid_q;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          lo_d  = lo_n;
          hi1_d = hi1_n;
          if (lo_n < hi1_n) begin
            mid_d   = mid_n;
            state_d = S_PROBE;
          end else begin
            index_d = (lo_n > last) ? last : lo_n;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    n_q     <= n_d;
    lo_q    <= lo_d;
    hi1_q   <= hi1_d;
    mid_q   <= mid_d;
    index_q <= index_d;
  end

  assign done_o  = done_q;
  assign index_o = index_q;

endmodule

[rtl/core/btl_div.sv]
module btl_div #(
  parameter int unsigned DW = 24,
  parameter int unsigned VW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;     // dividend bits shift out, quotient bits shift in
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], fits};
      rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/core/brightness_to_luminance_interpolator.sv]
// Brightness to luminance interpolator.
// Input channel (in_valid_i / in_stall_o) carries one word per item: a table
// write (level brightness, level luminance or step brightness) or a query.
// Every item gives exactly one result word on the output channel
// (out_valid_o / out_stall_i): write accepted, out of range, or a query result.
// Count registers are set through the plain write port (cfg_we_i); the user
// must write them only while idle, as the block itself does not enforce it.
// A full query runs four upper binary searches (one over the level table,
// three over the step table) on one shared search engine, where every probe
// waits on the registered table read, then goes through a shared multiplier
// and a restoring divider. One item is in work at a time: in_stall_o stays
// high until the result is handed to the output register. That register
// holds the result while the receiver stalls, and the next item may already
// be taken meanwhile.
// Reset empties the sequencer and output register and sets the counts to
// 1, 1, 0, 0; table contents are undefined until written.
module brightness_to_luminance_interpolator import btl_pkg::*; #(
  parameter int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int unsigned STEP_DEPTH  = STEP_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [IDX_W-1:0]   entry_index_i,
  input  logic [VAL_W-1:0]   entry_value_i,
  input  logic [VAL_W-1:0]   brightness_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [STAT_W-1:0]  status_o,
  output logic [IDX_W-1:0]   level_index_o,
  output logic [VAL_W-1:0]   luminance_o,
  output logic [X100_W-1:0]  luminance_x100_o,
  output logic [IDX_W-1:0]   step_index_o,
  output logic [VAL_W-1:0]   step_brightness_o,
  output logic               high_mode_o,
  output logic               extended_high_mode_o
);

  // Address and count widths
  localparam int unsigned LA    = $clog2(LEVEL_DEPTH);
  localparam int unsigned SA    = $clog2(STEP_DEPTH);
  localparam int unsigned LCW   = $clog2(LEVEL_DEPTH + 1);
  localparam int unsigned SCW   = $clog2(STEP_DEPTH + 1);
  localparam int unsigned IW    = (LCW > SCW) ? LCW : SCW;
  // Multiplier operands: |dlum| * |dstep| then * 100, and base * 100
  localparam int unsigned MA    = VAL_W + SA;
  localparam int unsigned MB    = (SA > SCALE_W) ? SA : SCALE_W;
  localparam int unsigned DW    = VAL_W + SA + SCALE_W;
  localparam int unsigned SUM_W = DW + 1;

  typedef enum logic [17:0] {
    S_IDLE     = 18'b000000000000000001,
    S_RD_LAST  = 18'b000000000000000010,
    S_CHK      = 18'b000000000000000100,
    S_SRCH_L   = 18'b000000000000001000,
    S_RD_A     = 18'b000000000000010000,
    S_RD_B     = 18'b000000000000100000,
    S_RD_C     = 18'b000000000001000000,
    S_RD_D     = 18'b000000000010000000,
    S_RD_E     = 18'b000000000100000000,
    S_SRCH_SLO = 18'b000000001000000000,
    S_SRCH_S   = 18'b000000010000000000,
    S_SRCH_SUP = 18'b000000100000000000,
    S_RD_STEP  = 18'b000001000000000000,
    S_MUL1     = 18'b000010000000000000,
    S_MUL2     = 18'b000100000000000000,
    S_MUL3     = 18'b001000000000000000,
    S_DIV      = 18'b010000000000000000,
    S_FIN      = 18'b100000000000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [CNT_W-1:0] lvl_cnt_q, stp_cnt_q, ui_cnt_q, hbm_cnt_q;
  logic [LCW-1:0]   nl;
  logic [SCW-1:0]   ns;

  // Tables
  logic [VAL_W-1:0] lbt_mem [LEVEL_DEPTH];
  logic [VAL_W-1:0] lum_mem [LEVEL_DEPTH];
  logic [VAL_W-1:0] stp_mem [STEP_DEPTH];
  logic [VAL_W-1:0] lbt_rd_q, lum_rd_q, stp_rd_q;
  logic [LA-1:0]    lbt_addr, lum_addr, wr_laddr;
  logic [SA-1:0]    stp_addr, wr_saddr;
  logic             lbt_we, lum_we, stp_we;

  // Handshake
  logic  in_acc;
  op_e   op;
  logic  out_free;

  // Search engine
  logic             srch_start, srch_done;
  logic [VAL_W-1:0] srch_key, srch_rd;
  logic [IW-1:0]    srch_n, srch_addr, srch_idx;

  // Divider
  logic             div_start, div_done;
  logic [DW-1:0]    div_quo;

  // Query working registers
  status_e           stat_q;
  logic [VAL_W-1:0]  brt_q, blo_q, bup_q;
  logic [VAL_W-1:0]  lum_q, lumlo_q, lum_ui_q, lum_hbm_q, sbrt_q;
  logic [LA-1:0]     up_q, lo_idx;
  logic [SA-1:0]     slo_q, s_q, sup_q;
  logic [DW-1:0]     p_q, q_q;
  logic              neg_q;
  logic [X100_W-1:0] base_q;

  // Arithmetic
  logic [VAL_W-1:0]   dl_mag;
  logic [SA-1:0]      ds_mag, dd_mag;
  logic               neg;
  logic [MA-1:0]      mul_a;
  logic [MB-1:0]      mul_b;
  logic [MA+MB-1:0]   mul_p;
  logic [SUM_W-1:0]   x_sum;
  logic [X100_W-1:0]  x100;
  logic [DW-1:0]      base_w;
  logic               reject;
  logic               hm_en, ehm_en;
  logic [CNT_W:0]     ui_m1, uh_m1;

  // Output register
  logic              out_valid_q;
  status_e           out_status_q;
  logic [IDX_W-1:0]  out_lidx_q, out_sidx_q;
  logic [VAL_W-1:0]  out_lum_q, out_sbrt_q;
  logic [X100_W-1:0] out_x100_q;
  logic              out_hm_q, out_ehm_q;

  // ---------------------------------------------------------------------
  // Counts used saturated to 1..depth
  // ---------------------------------------------------------------------
  always_comb begin
    if (lvl_cnt_q == '0) begin
      nl = LCW'(1);
    end else if (32'(lvl_cnt_q) > LEVEL_DEPTH) begin
      nl = LCW'(LEVEL_DEPTH);
    end else begin
      nl = LCW'(lvl_cnt_q);
    end
    if (stp_cnt_q == '0) begin
      ns = SCW'(1);
    end else if (32'(stp_cnt_q) > STEP_DEPTH) begin
      ns = SCW'(STEP_DEPTH);
    end else begin
      ns = SCW'(stp_cnt_q);
    end
  end

  // Flag enables: the user range must fit, and the high range after it
  assign hm_en  = (ui_cnt_q != '0) && (32'(ui_cnt_q) <= 32'(nl));
  assign ehm_en = (hbm_cnt_q != '0) &&
                  ((32'(ui_cnt_q) + 32'(hbm_cnt_q)) <= 32'(nl));
  assign ui_m1  = {1'b0, ui_cnt_q} - (CNT_W+1)'(1);
  assign uh_m1  = {1'b0, ui_cnt_q} + {1'b0, hbm_cnt_q} - (CNT_W+1)'(1);

  // ---------------------------------------------------------------------
  // Handshake and table writes
  // ---------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign op         = op_e'(operation_i);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Drop writes beyond the table depth; the word still gets its result
  assign lbt_we   = in_acc && (op == OP_LEVEL_BRT) && (32'(entry_index_i) < LEVEL_DEPTH);
  assign lum_we   = in_acc && (op == OP_LEVEL_LUM) && (32'(entry_index_i) < LEVEL_DEPTH);
  assign stp_we   = in_acc && (op == OP_STEP_BRT) && (32'(entry_index_i) < STEP_DEPTH);
  assign wr_laddr = LA'(entry_index_i);
  assign wr_saddr = SA'(entry_index_i);

  assign lo_idx = (up_q == '0) ? '0 : up_q - LA'(1);

  // Read address per table, chosen by the sequencer
  always_comb begin
    lbt_addr = '0;
    lum_addr = '0;
    stp_addr = '0;
    case (state_q)
      S_RD_LAST:  lbt_addr = LA'(nl - LCW'(1));
      S_SRCH_L:   lbt_addr = LA'(srch_addr);
      S_RD_A: begin
        lbt_addr = lo_idx;
        lum_addr = up_q;
      end
      S_RD_B: begin
        lbt_addr = up_q;
        lum_addr = lo_idx;
      end
      S_RD_C:     lum_addr = LA'(ui_m1);
      S_RD_D:     lum_addr = LA'(uh_m1);
      S_SRCH_SLO: stp_addr = SA'(srch_addr);
      S_SRCH_S:   stp_addr = SA'(srch_addr);
      S_SRCH_SUP: stp_addr = SA'(srch_addr);
      S_RD_STEP:  stp_addr = s_q;
      default: begin
        lbt_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (lbt_we) begin
      lbt_mem[wr_laddr] <= entry_value_i;
    end
    lbt_rd_q <= lbt_mem[lbt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (lum_we) begin
      lum_mem[wr_laddr] <= entry_value_i;
    end
    lum_rd_q <= lum_mem[lum_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stp_we) begin
      stp_mem[wr_saddr] <= entry_value_i;
    end
    stp_rd_q <= stp_mem[stp_addr];
  end

  // ---------------------------------------------------------------------
  // Shared search engine: level table first, then three step searches
  // ---------------------------------------------------------------------
  assign reject  = (brt_q > lbt_rd_q);
  assign srch_rd = (state_q == S_SRCH_L) ? lbt_rd_q : stp_rd_q;

  always_comb begin
    srch_start = 1'b0;
    srch_key   = brt_q;
    srch_n     = IW'(ns);
    case (state_q)
      S_CHK: begin
        srch_start = !reject;
        srch_n     = IW'(nl);
      end
      S_RD_E: begin
        srch_start = 1'b1;
        srch_key   = blo_q;
      end
      S_SRCH_SLO: srch_start = srch_done;
      S_SRCH_S: begin
        srch_start = srch_done;
        srch_key   = bup_q;
      end
      default: srch_start = 1'b0;
    endcase
  end

  btl_search #(
    .IW (IW)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (srch_start),
    .key_i     (srch_key),
    .n_i       (srch_n),
    .rd_addr_o (srch_addr),
    .rd_data_i (srch_rd),
    .done_o    (srch_done),
    .index_o   (srch_idx)
  );

  // ---------------------------------------------------------------------
  // Shared multiplier, then the serial divider
  // ---------------------------------------------------------------------
  assign dl_mag = (lum_q >= lumlo_q) ? lum_q - lumlo_q : lumlo_q - lum_q;
  assign ds_mag = (s_q >= slo_q) ? s_q - slo_q : slo_q - s_q;
  assign dd_mag = (sup_q >= slo_q) ? sup_q - slo_q : slo_q - sup_q;
  // Track the sign apart so the quotient truncates toward zero
  assign neg    = (lum_q < lumlo_q) ^ (s_q < slo_q) ^ (sup_q < slo_q);

  always_comb begin
    case (state_q)
      S_MUL1: begin
        mul_a = MA'(dl_mag);
        mul_b = MB'(ds_mag);
      end
      S_MUL2: begin
        mul_a = MA'(p_q);
        mul_b = MB'(LUM_SCALE);
      end
      default: begin
        mul_a = MA'(lumlo_q);
        mul_b = MB'(LUM_SCALE);
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign div_start = (state_q == S_MUL3) && (sup_q != slo_q);

  btl_div #(
    .DW (DW),
    .VW (SA)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (p_q),
    .divisor_i  (dd_mag),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Apply the signed correction to the base and saturate
  assign base_w = DW'(base_q);
  assign x_sum  = {1'b0, base_w} + {1'b0, q_q};

  always_comb begin
    if (neg_q) begin
      x100 = (q_q > base_w) ? '0 : X100_W'(base_w - q_q);
    end else begin
      x100 = (x_sum > SUM_W'(X100_MAX)) ? X100_MAX : X100_W'(x_sum);
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (op == OP_QUERY) ? S_RD_LAST : S_FIN;
        end
      end
      S_RD_LAST:  state_d = S_CHK;
      S_CHK:      state_d = reject ? S_FIN : S_SRCH_L;
      S_SRCH_L: begin
        if (srch_done) begin
          state_d = S_RD_A;
        end
      end
      S_RD_A:     state_d = S_RD_B;
      S_RD_B:     state_d = S_RD_C;
      S_RD_C:     state_d = S_RD_D;
      S_RD_D:     state_d = S_RD_E;
      S_RD_E:     state_d = S_SRCH_SLO;
      S_SRCH_SLO: begin
        if (srch_done) begin
          state_d = S_SRCH_S;
        end
      end
      S_SRCH_S: begin
        if (srch_done) begin
          state_d = S_SRCH_SUP;
        end
      end
      S_SRCH_SUP: begin
        if (srch_done) begin
          state_d = S_RD_STEP;
        end
      end
      S_RD_STEP:  state_d = S_MUL1;
      S_MUL1:     state_d = S_MUL2;
      S_MUL2:     state_d = S_MUL3;
      S_MUL3:     state_d = (sup_q != slo_q) ? S_DIV : S_FIN;
      S_DIV: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register can take the word
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      lvl_cnt_q   <= CNT_W'(1);
      stp_cnt_q   <= CNT_W'(1);
      ui_cnt_q    <= '0;
      hbm_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_LEVEL_COUNT: lvl_cnt_q <= cfg_wdata_i;
          CFG_STEP_COUNT:  stp_cnt_q <= cfg_wdata_i;
          CFG_UI_COUNT:    ui_cnt_q  <= cfg_wdata_i;
          CFG_HBM_COUNT:   hbm_cnt_q <= cfg_wdata_i;
          default:         lvl_cnt_q <= lvl_cnt_q;
        endcase
      end
    end
  end

  // Capture table reads, search results and products as the sequencer moves
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          brt_q  <= brightness_i;
          stat_q <= (op == OP_QUERY) ? STAT_DONE : STAT_WRITE;
        end
      end
      S_CHK: begin
        if (reject) begin
          stat_q <= STAT_RANGE;
        end
      end
      S_SRCH_L: begin
        if (srch_done) begin
          up_q <= LA'(srch_idx);
        end
      end
      S_RD_B: begin
        blo_q <= lbt_rd_q;
        lum_q <= lum_rd_q;
      end
      S_RD_C: begin
        bup_q   <= lbt_rd_q;
        lumlo_q <= lum_rd_q;
      end
      S_RD_D:     lum_ui_q <= lum_rd_q;
      S_RD_E:     lum_hbm_q <= lum_rd_q;
      S_SRCH_SLO: begin
        if (srch_done) begin
          slo_q <= SA'(srch_idx);
        end
      end
      S_SRCH_S: begin
        if (srch_done) begin
          s_q <= SA'(srch_idx);
        end
      end
      S_SRCH_SUP: begin
        if (srch_done) begin
          sup_q <= SA'(srch_idx);
        end
      end
      S_MUL1: begin
        sbrt_q <= stp_rd_q;
        p_q    <= DW'(mul_p);
        neg_q  <= neg;
      end
      S_MUL2:     p_q <= DW'(mul_p);
      S_MUL3: begin
        base_q <= X100_W'(mul_p);
        q_q    <= '0;
      end
      S_DIV: begin
        if (div_done) begin
          q_q <= div_quo;
        end
      end
      default: begin
        brt_q <= brt_q;
      end
    endcase
  end

  // Output register: load only when empty or being taken
  always_ff @(posedge clk_i) begin
    if ((state_q == S_FIN) && out_free) begin
      out_status_q <= stat_q;
      if (stat_q == STAT_DONE) begin
        out_lidx_q <= IDX_W'(up_q);
        out_lum_q  <= lum_q;
        out_x100_q <= x100;
        out_sidx_q <= IDX_W'(s_q);
        out_sbrt_q <= sbrt_q;
        out_hm_q   <= hm_en && (lum_q > lum_ui_q);
        out_ehm_q  <= ehm_en && (lum_q > lum_hbm_q);
      end else begin
        out_lidx_q <= '0;
        out_lum_q  <= '0;
        out_x100_q <= '0;
        out_sidx_q <= '0;
        out_sbrt_q <= '0;
        out_hm_q   <= 1'b0;
        out_ehm_q  <= 1'b0;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = out_status_q;
  assign level_index_o        = out_lidx_q;
  assign luminance_o          = out_lum_q;
  assign luminance_x100_o     = out_x100_q;
  assign step_index_o         = out_sidx_q;
  assign step_brightness_o    = out_sbrt_q;
  assign high_mode_o          = out_hm_q;
  assign extended_high_mode_o = out_ehm_q;

endmodule
